>>> sv/bhq_pkg.sv
package bhq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned OccW     = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic signed [KeyW-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key_out;
    logic [1:0]             status;
    logic [OccW-1:0]        occupancy;
  } out_item_t;

  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic signed [KeyW-1:0] new_key;
  } cell_ctrl_t;

endpackage

>>> sv/bhq_cell.sv
module bhq_cell (
  input  logic                            clk_i,
  input  bhq_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            valid_i,
  input  logic signed [bhq_pkg::KeyW-1:0] left_key_i,
  input  logic                            left_gt_i,
  input  logic signed [bhq_pkg::KeyW-1:0] right_key_i,
  output logic signed [bhq_pkg::KeyW-1:0] key_o,
  output logic                            gt_o
);
  import bhq_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;

  // An empty cell behaves as if it held a key above every other.
  assign gt_o  = !valid_i || (key_q > ctrl_i.new_key);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && gt_o) begin
      // The first cell above the new key takes it; those beyond shift up by one.
      key_d = left_gt_i ? left_key_i : ctrl_i.new_key;
    end else if (ctrl_i.rem) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> sv/binary_min_heap_queue_top.sv
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; the sorted row updates in one step,
// every cell comparing its key against the new one and taking from a neighbour.
// A result that is not taken stalls the input only while the output register is full.
// Reset (rst_ni low, asynchronous) empties the queue and clears the output valid;
// the stored keys are not cleared and need no clearing pass.
module binary_min_heap_queue_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bhq_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bhq_pkg::out_item_t   out_item_o
);
  import bhq_pkg::*;

  logic [CountW-1:0]      count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;
  cell_ctrl_t             ctrl;
  logic                   acc;
  logic signed [KeyW-1:0] cell_key [Capacity];
  logic                   cell_gt  [Capacity];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    ctrl         = '0;
    ctrl.new_key = in_item_i.key_in;
    count_d      = count_q;
    out_item_d.key_out = '0;
    out_item_d.status  = ST_OK;
    case (in_item_i.req_type)
      REQ_INSERT: begin
        if (count_q == CountW'(Capacity)) begin
          out_item_d.status = ST_FULL;
        end else begin
          ctrl.ins = acc;
          count_d  = count_q + CountW'(1);
        end
      end
      REQ_REMOVE: begin
        if (count_q == '0) begin
          out_item_d.status = ST_EMPTY;
        end else begin
          out_item_d.key_out = cell_key[0];
          ctrl.rem = acc;
          count_d  = count_q - CountW'(1);
        end
      end
      REQ_PEEK: begin
        if (count_q == '0) begin
          out_item_d.status = ST_EMPTY;
        end else begin
          out_item_d.key_out = cell_key[0];
        end
      end
      default: begin
      end
    endcase
    out_item_d.occupancy = OccW'(count_d);
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [KeyW-1:0] left_key, right_key;
    logic                   left_gt;
    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_next
      assign right_key = cell_key[i+1];
    end
    bhq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > CountW'(i)),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (acc) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> sv/bhq_checker.sv
module bhq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input bhq_pkg::in_item_t    in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input bhq_pkg::out_item_t   out_item_o
);
  import bhq_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Every accepted item yields a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after accepted item");

  // A full refusal reports a full queue.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |-> out_item_o.occupancy == OccW'(Capacity))
    else $error("full status with wrong occupancy");

  // An empty refusal reports an empty queue and a zero key.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EMPTY
      |-> out_item_o.occupancy == '0 && out_item_o.key_out == '0)
    else $error("empty status with wrong contents");

  // An insert always returns a zero key.
  a_insert_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.req_type == REQ_INSERT
      |=> out_item_o.key_out == '0)
    else $error("insert returned a key");

endmodule

bind binary_min_heap_queue_top bhq_checker u_bhq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
